// ===== hdl/tcd_pkg.sv =====
// shared types and constants of the trigger clock divider
package tcd_pkg;

    // default parameter values
    localparam int DEF_SAMPLE_WIDTH = 16;
    localparam int DEF_PERIOD_WIDTH = 24;
    localparam int DEF_MAX_DIVISION = 64;

    // fixed register widths
    localparam int CFG_IDX_W   = 3;
    localparam int DIVISION_W  = 7;
    localparam int LENGTH_W    = 24;
    localparam int DUTY_W      = 17;
    localparam int PULSE_W     = 31;
    localparam int ROUND_SHIFT = 16;

    // duty limits in Q1.16
    localparam logic [DUTY_W-1:0] DUTY_MIN   = 17'd655;
    localparam logic [DUTY_W-1:0] DUTY_MAX   = 17'd65536;
    localparam logic [DUTY_W-1:0] DUTY_RESET = 17'd32768;

    localparam logic [PULSE_W-1:0]    PULSE_MAX      = 31'h7FFF_FFFF;
    localparam logic [LENGTH_W-1:0]   FALLBACK_RESET = 24'd480;
    localparam logic [DIVISION_W-1:0] DIVISION_RESET = 7'd1;
    localparam logic [LENGTH_W-1:0]   PULSE_RESET    = 24'd1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLOCK_MODE = 3'd0,
        REG_THRESHOLD  = 3'd1,
        REG_DIVISION   = 3'd2,
        REG_PULSE      = 3'd3,
        REG_DUTY       = 3'd4,
        REG_FALLBACK   = 3'd5,
        REG_LEVEL      = 3'd6
    } cfg_reg_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_MUL1,
        S_MUL2,
        S_EMIT
    } tcd_state_t;

endpackage

// ===== hdl/tcd_serial_mod.sv =====
// bit-serial restoring remainder of a small count by the division
module tcd_serial_mod
    import tcd_pkg::*;
#(
    parameter int DIV_W = 7
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] numer,
    input  logic [DIV_W-1:0] divisor,
    output logic             busy,
    output logic [DIV_W-1:0] rem
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] num_reg, num_next;
    logic [DIV_W-1:0] div_reg, div_next;
    logic [DIV_W:0]   rem_reg, rem_next;
    logic [DIV_W:0]   trial;

    // one numerator bit per cycle, msb first
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg[DIV_W-1:0], num_reg[DIV_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            num_next  = numer;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = trial - {1'b0, div_reg};
            end
            else
            begin
                rem_next = trial;
            end
            num_next = {num_reg[DIV_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign rem  = rem_reg[DIV_W-1:0];

endmodule

// ===== hdl/tcd_serial_mul.sv =====
// shift-add multiplier, one multiplier bit per cycle, stops when bits run out
module tcd_serial_mul
    import tcd_pkg::*;
#(
    parameter int A_W = 31,
    parameter int B_W = 17
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               busy,
    output logic [A_W+B_W-1:0] product
);

    localparam int P_W = A_W + B_W;

    logic           busy_reg, busy_next;
    logic [P_W-1:0] acc_reg, acc_next;
    logic [P_W-1:0] mcand_reg, mcand_next;
    logic [B_W-1:0] mplier_reg, mplier_next;

    // add the shifted multiplicand for each set multiplier bit
    always_comb
    begin
        busy_next   = busy_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            acc_next    = '0;
            mcand_next  = P_W'(a);
            mplier_next = b;
        end
        else if (busy_reg)
        begin
            if (mplier_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[P_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[B_W-1:1]};
            end
        end
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign busy    = busy_reg;
    assign product = acc_reg;

endmodule

// ===== hdl/trigger_clock_divider_top.sv =====
// trigger clock divider: edge detection, serial divide counter and pulse length
//
// Usage: each input transfer on s_axis carries one trigger sample and one reset
// sample. Every input transfer gives exactly one output transfer on m_axis with
// the pulse value and the gate flag. Registers are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while the block is
// idle, which the block itself does not enforce. Without a trigger crossing
// an input transfer goes from S_IDLE to S_EMIT, which loads the result into
// the output register. A crossing first runs the serial remainder unit in
// S_MOD. A wrap in clock mode with a measured period also runs the shift-add
// multiplier twice, in S_MUL1 and S_MUL2, over the division bits up to its
// top set bit and over the duty bits. The block takes one item at a time: the
// next input transfer is accepted only once the result is loaded and the
// sequencer is back in S_IDLE.
// A stalled receiver holds only the one result in the output register; a
// further item waits for the output register before it completes.
// Reset clears the control state (not the payload or datapath registers)
// and the registers take their documented defaults; no clearing pass is needed.
module trigger_clock_divider_top
    import tcd_pkg::*;
#(
    parameter int  SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int  PERIOD_WIDTH = DEF_PERIOD_WIDTH,
    parameter int  MAX_DIVISION = DEF_MAX_DIVISION,
    localparam int IN_W  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((SAMPLE_WIDTH + 1 + 7) / 8) * 8,
    localparam int CFG_W = (SAMPLE_WIDTH > LENGTH_W) ? SAMPLE_WIDTH : LENGTH_W
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // fields from bit 0: trigger_sample, reset_sample
    input  logic [IN_W-1:0]      s_axis_tdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // fields from bit 0: pulse_out, gate
    output logic [OUT_W-1:0]     m_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int DIV_W = $clog2(MAX_DIVISION + 1);
    localparam int EC_W  = $clog2(MAX_DIVISION);
    localparam int A_W   = PERIOD_WIDTH + DIV_W;
    localparam int MP_W  = A_W + DUTY_W;
    localparam int LW    = MP_W + 1 - ROUND_SHIFT;
    localparam int CW    = (LW > PULSE_W) ? LW : PULSE_W;

    // configuration registers
    logic                  clock_mode_reg;
    logic signed [SW-1:0]  threshold_reg;
    logic [DIVISION_W-1:0] division_reg;
    logic [LENGTH_W-1:0]   pulse_samples_reg;
    logic [DUTY_W-1:0]     duty_reg;
    logic [LENGTH_W-1:0]   fallback_reg;
    logic signed [SW-1:0]  level_reg;

    // block state
    tcd_state_t            state_reg, state_next;
    logic signed [SW-1:0]  prev_trig_reg, prev_trig_next;
    logic signed [SW-1:0]  prev_rst_reg, prev_rst_next;
    logic [EC_W-1:0]       edge_count_reg, edge_count_next;
    logic [PULSE_W-1:0]    pulse_rem_reg, pulse_rem_next;
    logic [PERIOD_WIDTH-1:0] since_edge_reg, since_edge_next;
    logic [PERIOD_WIDTH-1:0] period_reg, period_next;
    logic                  out_valid_reg, out_valid_next;
    logic signed [SW-1:0]  pulse_out_reg, pulse_out_next;
    logic                  gate_reg, gate_next;

    logic signed [SW-1:0]  trig_smp;
    logic signed [SW-1:0]  rst_smp;
    logic                  in_fire;
    logic                  rst_cross;
    logic                  rise;
    logic [DIV_W-1:0]      div_eff;
    logic [DUTY_W-1:0]     duty_c;
    logic [PULSE_W-1:0]    ps_len;
    logic [PULSE_W-1:0]    fb_len;
    logic [PULSE_W-1:0]    clk_len;
    logic [MP_W:0]         rnd_sum;
    logic [CW-1:0]         rnd_x;

    logic                  mod_start;
    logic [DIV_W-1:0]      mod_numer;
    logic                  mod_busy;
    logic [DIV_W-1:0]      mod_rem;
    logic                  mul_start;
    logic [A_W-1:0]        mul_a;
    logic [DUTY_W-1:0]     mul_b;
    logic                  mul_busy;
    logic [MP_W-1:0]       mul_prod;

    assign trig_smp      = s_axis_tdata[SW-1:0];
    assign rst_smp       = s_axis_tdata[2*SW-1:SW];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // crossing detection against the shared threshold
    assign rst_cross = (prev_rst_reg <= threshold_reg) && (rst_smp > threshold_reg);
    assign rise      = (prev_trig_reg <= threshold_reg) && (trig_smp > threshold_reg);

    // effective division, clamped to one and the maximum
    always_comb
    begin
        if (division_reg == '0)
        begin
            div_eff = DIV_W'(1);
        end
        else if (int'(division_reg) > MAX_DIVISION)
        begin
            div_eff = DIV_W'(MAX_DIVISION);
        end
        else
        begin
            div_eff = DIV_W'(division_reg);
        end
    end

    // duty clamp
    always_comb
    begin
        if (duty_reg < DUTY_MIN)
        begin
            duty_c = DUTY_MIN;
        end
        else if (duty_reg > DUTY_MAX)
        begin
            duty_c = DUTY_MAX;
        end
        else
        begin
            duty_c = duty_reg;
        end
    end

    // fixed lengths, zero means one sample
    assign ps_len = (pulse_samples_reg == '0) ? PULSE_W'(1) : PULSE_W'(pulse_samples_reg);
    assign fb_len = (fallback_reg == '0) ? PULSE_W'(1) : PULSE_W'(fallback_reg);

    // clock mode length: round, saturate, at least one
    assign rnd_sum = {1'b0, mul_prod} + (MP_W + 1)'(32768);
    assign rnd_x   = CW'(rnd_sum[MP_W:ROUND_SHIFT]);
    always_comb
    begin
        if (rnd_x > CW'(PULSE_MAX))
        begin
            clk_len = PULSE_MAX;
        end
        else if (rnd_x == '0)
        begin
            clk_len = PULSE_W'(1);
        end
        else
        begin
            clk_len = PULSE_W'(rnd_x);
        end
    end

    // sequencer and state update
    always_comb
    begin
        logic [EC_W-1:0]         ec_v;
        logic [PULSE_W-1:0]      pr_v;
        logic [PERIOD_WIDTH-1:0] se_v;
        logic [PERIOD_WIDTH-1:0] pm_v;
        logic                    active;

        state_next      = state_reg;
        prev_trig_next  = prev_trig_reg;
        prev_rst_next   = prev_rst_reg;
        edge_count_next = edge_count_reg;
        pulse_rem_next  = pulse_rem_reg;
        since_edge_next = since_edge_reg;
        period_next     = period_reg;
        out_valid_next  = out_valid_reg;
        pulse_out_next  = pulse_out_reg;
        gate_next       = gate_reg;
        mod_start       = 1'b0;
        mod_numer       = '0;
        mul_start       = 1'b0;
        mul_a           = '0;
        mul_b           = '0;
        ec_v            = edge_count_reg;
        pr_v            = pulse_rem_reg;
        se_v            = since_edge_reg;
        pm_v            = period_reg;
        active          = (pulse_rem_reg != '0);

        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (rst_cross)
                    begin
                        ec_v = '0;
                        pr_v = '0;
                        if (clock_mode_reg)
                        begin
                            se_v = '0;
                            pm_v = '0;
                        end
                    end
                    if (rise)
                    begin
                        if (clock_mode_reg)
                        begin
                            if (se_v != '0)
                            begin
                                pm_v = se_v;
                            end
                            se_v = '0;
                        end
                        mod_start  = 1'b1;
                        mod_numer  = DIV_W'(ec_v) + DIV_W'(1);
                        state_next = S_MOD;
                    end
                    else
                    begin
                        if (clock_mode_reg && (se_v != '1))
                        begin
                            se_v = se_v + PERIOD_WIDTH'(1);
                        end
                        state_next = S_EMIT;
                    end
                    edge_count_next = ec_v;
                    pulse_rem_next  = pr_v;
                    since_edge_next = se_v;
                    period_next     = pm_v;
                    prev_trig_next  = trig_smp;
                    prev_rst_next   = rst_smp;
                end
            end
            S_MOD:
            begin
                if (!mod_busy)
                begin
                    edge_count_next = mod_rem[EC_W-1:0];
                    state_next      = S_EMIT;
                    if (mod_rem == '0)
                    begin
                        if (!clock_mode_reg)
                        begin
                            pulse_rem_next = ps_len;
                        end
                        else if (period_reg == '0)
                        begin
                            pulse_rem_next = fb_len;
                        end
                        else
                        begin
                            mul_start  = 1'b1;
                            mul_a      = A_W'(period_reg);
                            mul_b      = DUTY_W'(div_eff);
                            state_next = S_MUL1;
                        end
                    end
                end
            end
            S_MUL1:
            begin
                // period times division done, now times duty
                if (!mul_busy)
                begin
                    mul_start  = 1'b1;
                    mul_a      = mul_prod[A_W-1:0];
                    mul_b      = duty_c;
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                if (!mul_busy)
                begin
                    pulse_rem_next = clk_len;
                    state_next     = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    pulse_out_next = active ? level_reg : '0;
                    gate_next      = active;
                    if (active)
                    begin
                        pulse_rem_next = pulse_rem_reg - PULSE_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_mode_reg    <= 1'b0;
            threshold_reg     <= '0;
            division_reg      <= DIVISION_RESET;
            pulse_samples_reg <= PULSE_RESET;
            duty_reg          <= DUTY_RESET;
            fallback_reg      <= FALLBACK_RESET;
            level_reg         <= {1'b0, {(SW - 1){1'b1}}};
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CLOCK_MODE: clock_mode_reg    <= cfg_data[0];
                REG_THRESHOLD:  threshold_reg     <= cfg_data[SW-1:0];
                REG_DIVISION:   division_reg      <= cfg_data[DIVISION_W-1:0];
                REG_PULSE:      pulse_samples_reg <= cfg_data[LENGTH_W-1:0];
                REG_DUTY:       duty_reg          <= cfg_data[DUTY_W-1:0];
                REG_FALLBACK:   fallback_reg      <= cfg_data[LENGTH_W-1:0];
                REG_LEVEL:      level_reg         <= cfg_data[SW-1:0];
                default:        ;
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            prev_trig_reg  <= '0;
            prev_rst_reg   <= '0;
            edge_count_reg <= '0;
            pulse_rem_reg  <= '0;
            since_edge_reg <= '0;
            period_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            prev_trig_reg  <= prev_trig_next;
            prev_rst_reg   <= prev_rst_next;
            edge_count_reg <= edge_count_next;
            pulse_rem_reg  <= pulse_rem_next;
            since_edge_reg <= since_edge_next;
            period_reg     <= period_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        pulse_out_reg <= pulse_out_next;
        gate_reg      <= gate_next;
    end

    tcd_serial_mod #(
        .DIV_W (DIV_W)
    ) u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mod_start),
        .numer   (mod_numer),
        .divisor (div_eff),
        .busy    (mod_busy),
        .rem     (mod_rem)
    );

    tcd_serial_mul #(
        .A_W (A_W),
        .B_W (DUTY_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .product (mul_prod)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({gate_reg, pulse_out_reg});

    // a closed gate always carries a zero value
    a_gate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !gate_reg) |-> (pulse_out_reg == '0))
        else $error("pulse value without gate");

    // one item at a time: no transfer straight after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // the multiplier only runs with a measured period
    a_mul_period: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL1) |-> (period_reg != '0 && clock_mode_reg))
        else $error("clock length computed without a period");

endmodule

// ===== verif/trigger_clock_divider_checker.sv =====
// scoreboard for the trigger clock divider: predicts each output transfer and compares it
module trigger_clock_divider_checker
    import tcd_pkg::*;
#(
    parameter int  SAMPLE_W = DEF_SAMPLE_WIDTH,
    parameter int  PERIOD_W = DEF_PERIOD_WIDTH,
    parameter int  MAX_DIV  = DEF_MAX_DIVISION,
    localparam int IN_W  = ((2 * SAMPLE_W + 7) / 8) * 8,
    localparam int OUT_W = ((SAMPLE_W + 1 + 7) / 8) * 8,
    localparam int CFG_W = (SAMPLE_W > LENGTH_W) ? SAMPLE_W : LENGTH_W
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // fields from bit 0: trigger_sample, reset_sample
    input  logic [IN_W-1:0]      s_axis_tdata,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    // fields from bit 0: pulse_out, gate
    input  logic [OUT_W-1:0]     m_axis_tdata,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic    gate;
        sample_t pulse;
    } divider_out_t;

    // register copies
    logic                  clock_mode;
    sample_t               threshold;
    logic [DIVISION_W-1:0] division;
    logic [LENGTH_W-1:0]   pulse_len;
    logic [DUTY_W-1:0]     duty;
    logic [LENGTH_W-1:0]   fallback_len;
    sample_t               level;

    // divider state
    sample_t               prev_trig;
    sample_t               prev_rst;
    int unsigned           edge_cnt;
    longint unsigned       pulse_left;
    logic [PERIOD_W-1:0]   since_edge;
    logic [PERIOD_W-1:0]   period;

    divider_out_t          expected_q[$];

    // pulse length in clock mode from duty, division and measured period, else the fallback length
    function automatic longint unsigned clock_length(int unsigned div_eff);
        longint unsigned d;
        longint unsigned len;
        if (period == 0)
            return (fallback_len == 0) ? 1 : fallback_len;
        d = duty;
        if (d < DUTY_MIN)
            d = DUTY_MIN;
        if (d > DUTY_MAX)
            d = DUTY_MAX;
        len = (d * div_eff * period + 64'd32768) >> ROUND_SHIFT;
        if (len == 0)
            len = 1;
        if (len > PULSE_MAX)
            len = PULSE_MAX;
        return len;
    endfunction

    // advance the divider by one sample pair and give the output it shows
    function automatic divider_out_t divide_sample(sample_t trig, sample_t rsmp);
        int unsigned  div_eff;
        logic         rising;
        divider_out_t res;
        if (division == 0)
            div_eff = 1;
        else if (division > MAX_DIV)
            div_eff = MAX_DIV;
        else
            div_eff = division;

        // reset crossing comes first
        if (prev_rst <= threshold && rsmp > threshold) begin
            edge_cnt   = 0;
            pulse_left = 0;
            if (clock_mode) begin
                since_edge = '0;
                period     = '0;
            end
        end

        // trigger crossing, counted modulo the division
        rising = (prev_trig <= threshold) && (trig > threshold);
        if (rising) begin
            if (clock_mode) begin
                if (since_edge != 0)
                    period = since_edge;
                since_edge = '0;
            end
            edge_cnt = (edge_cnt + 1) % div_eff;
            if (edge_cnt == 0) begin
                if (clock_mode)
                    pulse_left = clock_length(div_eff);
                else
                    pulse_left = (pulse_len == 0) ? 1 : pulse_len;
            end
        end
        else if (clock_mode && since_edge != '1) begin
            since_edge = since_edge + 1'b1;
        end

        prev_trig = trig;
        prev_rst  = rsmp;

        // output, then count the pulse down
        res.gate  = (pulse_left != 0);
        res.pulse = res.gate ? level : '0;
        if (res.gate)
            pulse_left = pulse_left - 1;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        divider_out_t got;
        divider_out_t want;
        if (!rst_n)
        begin
            clock_mode   = 1'b0;
            threshold    = '0;
            division     = DIVISION_RESET;
            pulse_len    = PULSE_RESET;
            duty         = DUTY_RESET;
            fallback_len = FALLBACK_RESET;
            level        = sample_t'(2 ** (SAMPLE_W - 1) - 1);
            prev_trig    = '0;
            prev_rst     = '0;
            edge_cnt     = 0;
            pulse_left   = 0;
            since_edge   = '0;
            period       = '0;
            fail_count   = 0;
            expected_q.delete();
            outstanding <= 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CLOCK_MODE: clock_mode   = cfg_data[0];
                    REG_THRESHOLD:  threshold    = cfg_data[SAMPLE_W-1:0];
                    REG_DIVISION:   division     = cfg_data[DIVISION_W-1:0];
                    REG_PULSE:      pulse_len    = cfg_data[LENGTH_W-1:0];
                    REG_DUTY:       duty         = cfg_data[DUTY_W-1:0];
                    REG_FALLBACK:   fallback_len = cfg_data[LENGTH_W-1:0];
                    REG_LEVEL:      level        = cfg_data[SAMPLE_W-1:0];
                    default: ;
                endcase
            end

            // output transfer against the oldest expectation
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[SAMPLE_W:0];
                if (expected_q.size() == 0)
                begin
                    $error("output transfer with nothing expected: pulse_out %0d, gate %0b",
                           got.pulse, got.gate);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.pulse !== want.pulse)
                    begin
                        $error("pulse_out mismatch: expected %0d, actual %0d",
                               want.pulse, got.pulse);
                        fail_count++;
                    end
                    if (got.gate !== want.gate)
                    begin
                        $error("gate mismatch: expected %0b, actual %0b", want.gate, got.gate);
                        fail_count++;
                    end
                end
            end

            // input transfer
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(divide_sample(s_axis_tdata[SAMPLE_W-1:0],
                                                   s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]));

            outstanding <= expected_q.size();
        end
    end

endmodule

// ===== verif/trigger_clock_divider_top_tb.sv =====
// testbench top for the trigger clock divider: stimulus, handshake idling and verdict
module trigger_clock_divider_top_tb;
    import tcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W       = DEF_SAMPLE_WIDTH;
    localparam int IN_W           = ((2 * SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_W          = ((SAMPLE_W + 1 + 7) / 8) * 8;
    localparam int CFG_W          = (SAMPLE_W > LENGTH_W) ? SAMPLE_W : LENGTH_W;
    localparam int SETTLE_CYCLES  = 2 * DIVISION_W + 26;
    localparam int PHASES         = 24;
    localparam int PHASE_ITEMS    = 64;
    localparam int CALM_PHASES    = 3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SMP_MIN        = -(2 ** (SAMPLE_W - 1));
    localparam int SMP_MAX        = 2 ** (SAMPLE_W - 1) - 1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic [IN_W-1:0]      s_axis_tdata  = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]     cfg_data      = '0;

    int fail_count;
    int outstanding;
    int gap_pct     = 0;
    int stall_pct   = 0;
    int stall_left  = 0;
    int idle_cycles = 0;
    int cur_thr     = 0;

    trigger_clock_divider_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    trigger_clock_divider_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver stalls in bursts, each started at random with chance stall_pct percent
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
        else if (stall_pct > 0 && $urandom_range(99) < stall_pct)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(5, 1) - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // sample at or below the threshold, sometimes exactly on it
    function automatic int below_level(int thr);
        case ($urandom_range(7))
            0:       return thr;
            1:       return SMP_MIN;
            default: return SMP_MIN + int'($urandom_range(thr - SMP_MIN));
        endcase
    endfunction

    // sample above the threshold where one exists
    function automatic int above_level(int thr);
        if (thr >= SMP_MAX)
            return SMP_MAX;
        case ($urandom_range(7))
            0:       return thr + 1;
            1:       return SMP_MAX;
            default: return thr + 1 + int'($urandom_range(SMP_MAX - 1 - thr));
        endcase
    endfunction

    // register word with random bits above the register width
    function automatic logic [CFG_W-1:0] with_junk(int w, int value);
        logic [CFG_W-1:0] word;
        logic [CFG_W-1:0] mask;
        mask = (CFG_W'(1) << w) - 1'b1;
        word = CFG_W'($urandom);
        return (word << w) | (CFG_W'(value) & mask);
    endfunction

    // one input transfer, with an optional gap in front
    task automatic send_item(int trig, int rsmp);
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge clk);
        end
        s_axis_tdata  <= {sample_t'(rsmp), sample_t'(trig)};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // stop sending and wait until every result is back and the block is quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // write every register while idle
    task automatic apply_settings(int mode, int thr, int div, int pls, int dty, int fb,
                                  int lvl);
        settle();
        write_reg(REG_CLOCK_MODE, with_junk(1, mode));
        write_reg(REG_THRESHOLD,  with_junk(SAMPLE_W, thr));
        write_reg(REG_DIVISION,   with_junk(DIVISION_W, div));
        write_reg(REG_PULSE,      with_junk(LENGTH_W, pls));
        write_reg(REG_DUTY,       with_junk(DUTY_W, dty));
        write_reg(REG_FALLBACK,   with_junk(LENGTH_W, fb));
        write_reg(REG_LEVEL,      with_junk(SAMPLE_W, lvl));
        cfg_we  <= 1'b0;
        cur_thr  = thr;
    endtask

    initial
    begin
        int ph;
        int k;
        int mode;
        int thr;
        int div;
        int pls;
        int dty;
        int fb;
        int lvl;
        int lo_len;
        int hi_len;
        int pos;
        int trig;
        int rsmp;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: trigger mode, divide by one, one-sample pulse
        send_item(0, 0);
        send_item(1, 0);
        send_item(SMP_MAX, 0);
        send_item(SMP_MIN, 0);
        send_item(SMP_MAX, SMP_MIN);
        send_item(0, SMP_MAX);
        send_item(1, SMP_MIN);
        // reset and trigger crossing in the same sample
        send_item(-5, -5);
        send_item(5, 5);

        // clock mode, duty below its floor, zero fallback
        apply_settings(1, 0, 2, 3, 0, 0, SMP_MIN);
        send_item(-1, 0);
        send_item(1, 0);
        send_item(-1, 0);
        send_item(-1, 0);
        send_item(-1, 0);
        send_item(1, 0);
        send_item(0, 0);

        // lowest threshold, division zero, duty above full scale
        apply_settings(1, SMP_MIN, 0, 0, 'h1FFFF, 0, SMP_MAX);
        send_item(SMP_MIN, SMP_MIN);
        send_item(7, 0);
        send_item(SMP_MIN, SMP_MIN);
        send_item(SMP_MIN, 0);
        send_item(SMP_MAX, 0);

        for (ph = 0; ph < PHASES; ph++)
        begin
            // settings: the first phase at the upper extremes, then random
            if (ph == 0)
            begin
                mode = 1;
                thr  = SMP_MAX - 1;
                div  = 127;
                pls  = 'hFFFFFF;
                dty  = 'h1FFFF;
                fb   = 'hFFFFFF;
                lvl  = SMP_MAX;
            end
            else
            begin
                mode = $urandom_range(1);
                case ($urandom_range(9))
                    0:       thr = SMP_MIN;
                    1:       thr = SMP_MAX;
                    2, 3:    thr = 0;
                    4, 5:    thr = int'($urandom_range(2000)) - 1000;
                    default: thr = SMP_MIN + int'($urandom_range(SMP_MAX - SMP_MIN));
                endcase
                case ($urandom_range(9))
                    0:       div = 0;
                    1:       div = DEF_MAX_DIVISION;
                    2:       div = $urandom_range(127, DEF_MAX_DIVISION + 1);
                    3:       div = $urandom_range(DEF_MAX_DIVISION, 1);
                    default: div = $urandom_range(6, 1);
                endcase
                case ($urandom_range(7))
                    0:       pls = 0;
                    1:       pls = 'hFFFFFF;
                    2:       pls = $urandom_range('hFFFFFF);
                    default: pls = $urandom_range(12, 1);
                endcase
                case ($urandom_range(7))
                    0:       dty = 0;
                    1:       dty = DUTY_MIN;
                    2:       dty = DUTY_MAX;
                    3:       dty = 'h1FFFF;
                    4:       dty = $urandom_range('h1FFFF);
                    default: dty = $urandom_range(DUTY_MAX, DUTY_MIN);
                endcase
                case ($urandom_range(7))
                    0:       fb = 0;
                    1:       fb = 'hFFFFFF;
                    2:       fb = $urandom_range('hFFFFFF);
                    default: fb = $urandom_range(40, 1);
                endcase
                case ($urandom_range(5))
                    0:       lvl = SMP_MIN;
                    1:       lvl = SMP_MAX;
                    default: lvl = SMP_MIN + int'($urandom_range(SMP_MAX - SMP_MIN));
                endcase
            end
            apply_settings(mode, thr, div, pls, dty, fb, lvl);

            // idling for this phase, none towards the end
            if (ph >= PHASES - CALM_PHASES)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                case ($urandom_range(3))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    2: gap_pct = 30;
                    3: gap_pct = 60;
                endcase
                case ($urandom_range(3))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    2: stall_pct = 30;
                    3: stall_pct = 60;
                endcase
            end

            // square wave around the threshold with rare reset pulses and some noise
            lo_len = $urandom_range(12, 1);
            hi_len = $urandom_range(4, 1);
            pos    = 0;
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(99) < 12)
                begin
                    trig = $urandom;
                    rsmp = $urandom;
                end
                else
                begin
                    trig = (pos >= lo_len) ? above_level(cur_thr) : below_level(cur_thr);
                    rsmp = ($urandom_range(99) < 3) ? above_level(cur_thr)
                                                    : below_level(cur_thr);
                    pos++;
                    if (pos == lo_len + hi_len)
                    begin
                        pos = 0;
                        if ($urandom_range(3) == 0)
                        begin
                            lo_len = $urandom_range(12, 1);
                            hi_len = $urandom_range(4, 1);
                        end
                    end
                end
                send_item(trig, rsmp);
            end
        end

        settle();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
